// ===== src/kwcs_pkg.sv =====
// Package: sizes, command and state types shared by the column select block.
`timescale 1ns / 1ps
package kwcs_pkg;

  localparam int MAX_COLUMNS  = 1024;
  localparam int SCORE_BITS   = 16;
  localparam int ADDR_BITS    = $clog2(MAX_COLUMNS);
  localparam int COUNT_BITS   = $clog2(MAX_COLUMNS + 1);
  localparam int WINNER_LIMIT = 64;
  localparam int WC_BITS      = 7;
  localparam int INDEX_BITS   = 10;
  localparam int IN_SCORE_BITS = 16;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_STORE_RUN,
    CMD_RUN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                 op;
    logic [ADDR_BITS-1:0]    addr;
    logic [SCORE_BITS-1:0]   score;
    logic [COUNT_BITS-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EMIT
  } back_state_t;

endpackage

// ===== src/kwcs_ifs.sv =====
// Interfaces: column score input channel and winner output channel.
`timescale 1ns / 1ps
interface kwcs_col_if;
  logic                               valid;
  logic                               ready;
  logic [kwcs_pkg::IN_SCORE_BITS-1:0] overlap_score;
  logic                               last_column;

  modport source(output valid, output overlap_score, output last_column, input ready);
  modport sink(input valid, input overlap_score, input last_column, output ready);
endinterface

interface kwcs_win_if;
  logic                            valid;
  logic                            ready;
  logic [kwcs_pkg::INDEX_BITS-1:0] winner_index;
  logic                            last_winner;

  modport source(output valid, output winner_index, output last_winner, input ready);
  modport sink(input valid, input winner_index, input last_winner, output ready);
endinterface

// ===== src/kwcs_front.sv =====
// Front end: accepts column words, tracks the load count and issues commands.
`timescale 1ns / 1ps
module kwcs_front (
  input  logic                   clk,
  input  logic                   rst,
  kwcs_col_if.sink               col_in,
  input  kwcs_pkg::fifo_status_t fifo_status,
  output logic                   push,
  output kwcs_pkg::cmd_t         cmd
);

  logic [kwcs_pkg::COUNT_BITS-1:0] loaded_count;
  logic [kwcs_pkg::COUNT_BITS-1:0] loaded_count_next;
  logic                            accept;
  logic                            has_room;

  assign col_in.ready = !fifo_status.full;
  assign accept       = col_in.valid && col_in.ready;
  assign has_room     = loaded_count < kwcs_pkg::COUNT_BITS'(kwcs_pkg::MAX_COLUMNS);

  always_comb begin
    loaded_count_next = loaded_count;
    push              = 1'b0;
    cmd.addr          = loaded_count[kwcs_pkg::ADDR_BITS-1:0];
    cmd.score         = col_in.overlap_score[kwcs_pkg::SCORE_BITS-1:0];
    cmd.count         = has_room ? loaded_count + kwcs_pkg::COUNT_BITS'(1) : loaded_count;
    cmd.op            = kwcs_pkg::CMD_STORE;
    if (has_room && col_in.last_column) begin
      cmd.op = kwcs_pkg::CMD_STORE_RUN;
    end else if (col_in.last_column) begin
      cmd.op = kwcs_pkg::CMD_RUN;
    end
    if (accept) begin
      // past the store limit a plain word is dropped; a last mark still ends the set
      push = has_room || col_in.last_column;
      if (col_in.last_column) begin
        loaded_count_next = '0;
      end else if (has_room) begin
        loaded_count_next = loaded_count + kwcs_pkg::COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
    end else begin
      loaded_count <= loaded_count_next;
    end
  end

endmodule

// ===== src/kwcs_cmd_fifo.sv =====
// Two-entry command queue between the front end and the selection engine.
`timescale 1ns / 1ps
module kwcs_cmd_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  kwcs_pkg::cmd_t         wr_cmd,
  input  logic                   pop,
  output kwcs_pkg::cmd_t         rd_cmd,
  output kwcs_pkg::fifo_status_t status
);

  kwcs_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign status.full  = fill == 2'd2;
  assign status.empty = fill == 2'd0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/kwcs_back.sv =====
// Selection engine: owns the score memory, runs the winner scans, drives results.
`timescale 1ns / 1ps
module kwcs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  kwcs_pkg::cmd_t               cmd,
  input  kwcs_pkg::fifo_status_t       fifo_status,
  input  logic [kwcs_pkg::WC_BITS-1:0] winner_count,
  output logic                         pop,
  kwcs_win_if.source                   win_out
);

  localparam int AB = kwcs_pkg::ADDR_BITS;
  localparam int CB = kwcs_pkg::COUNT_BITS;
  localparam int SB = kwcs_pkg::SCORE_BITS;
  localparam int WB = kwcs_pkg::WC_BITS;

  logic [SB-1:0] score_store [kwcs_pkg::MAX_COLUMNS];
  logic [SB-1:0] rd_data;
  logic          mem_we;
  logic [AB-1:0] mem_addr;
  logic [SB-1:0] mem_wdata;

  kwcs_pkg::back_state_t state, state_next;

  logic [CB-1:0] set_count, set_count_next;
  logic [CB-1:0] issue_cnt, issue_cnt_next;
  logic          rd_valid, rd_valid_next;
  logic [AB-1:0] rd_idx, rd_idx_next;
  logic [SB-1:0] best_val, best_val_next;
  logic [AB-1:0] best_idx, best_idx_next;
  logic [WB-1:0] rounds, rounds_next;
  logic [WB-1:0] round, round_next;
  logic          out_valid, out_valid_next;
  logic [kwcs_pkg::INDEX_BITS-1:0] out_index, out_index_next;
  logic          out_last, out_last_next;
  logic [WB-1:0] rounds_sat;

  assign rounds_sat = (winner_count > WB'(kwcs_pkg::WINNER_LIMIT)) ?
                      WB'(kwcs_pkg::WINNER_LIMIT) : winner_count;

  assign win_out.valid        = out_valid;
  assign win_out.winner_index = out_index;
  assign win_out.last_winner  = out_last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      score_store[mem_addr] <= mem_wdata;
    end
    rd_data <= score_store[mem_addr];
  end

  always_comb begin
    state_next     = state;
    set_count_next = set_count;
    issue_cnt_next = issue_cnt;
    rd_valid_next  = 1'b0;
    rd_idx_next    = rd_idx;
    best_val_next  = best_val;
    best_idx_next  = best_idx;
    rounds_next    = rounds;
    round_next     = round;
    out_valid_next = out_valid && !win_out.ready;
    out_index_next = out_index;
    out_last_next  = out_last;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = cmd.addr;
    mem_wdata      = cmd.score;

    case (state)
      kwcs_pkg::B_IDLE: begin
        if (!fifo_status.empty) begin
          pop = 1'b1;
          if (cmd.op inside {kwcs_pkg::CMD_STORE, kwcs_pkg::CMD_STORE_RUN}) begin
            mem_we = 1'b1;
          end
          if (cmd.op inside {kwcs_pkg::CMD_STORE_RUN, kwcs_pkg::CMD_RUN}) begin
            set_count_next = cmd.count;
            rounds_next    = rounds_sat;
            round_next     = '0;
            issue_cnt_next = '0;
            best_val_next  = '0;
            best_idx_next  = '0;
            if (rounds_sat != '0) begin
              state_next = kwcs_pkg::B_SCAN;
            end
          end
        end
      end

      kwcs_pkg::B_SCAN: begin
        mem_addr = issue_cnt[AB-1:0];
        if (issue_cnt < set_count) begin
          issue_cnt_next = issue_cnt + CB'(1);
          rd_valid_next  = 1'b1;
          rd_idx_next    = issue_cnt[AB-1:0];
        end
        if (rd_valid) begin
          // strict compare keeps the lowest index among equal scores
          if (rd_data > best_val) begin
            best_val_next = rd_data;
            best_idx_next = rd_idx;
          end
          if (CB'(rd_idx) == set_count - CB'(1)) begin
            state_next = kwcs_pkg::B_EMIT;
          end
        end
      end

      kwcs_pkg::B_EMIT: begin
        mem_addr  = best_idx;
        mem_wdata = '0;
        if (!out_valid || win_out.ready) begin
          mem_we         = 1'b1;
          out_valid_next = 1'b1;
          out_index_next = kwcs_pkg::INDEX_BITS'(best_idx);
          out_last_next  = round == rounds - WB'(1);
          round_next     = round + WB'(1);
          issue_cnt_next = '0;
          best_val_next  = '0;
          best_idx_next  = '0;
          if (round == rounds - WB'(1)) begin
            state_next = kwcs_pkg::B_IDLE;
          end else begin
            state_next = kwcs_pkg::B_SCAN;
          end
        end
      end

      default: begin
        state_next = kwcs_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kwcs_pkg::B_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    set_count <= set_count_next;
    issue_cnt <= issue_cnt_next;
    rd_idx    <= rd_idx_next;
    best_val  <= best_val_next;
    best_idx  <= best_idx_next;
    rounds    <= rounds_next;
    round     <= round_next;
    out_index <= out_index_next;
    out_last  <= out_last_next;
  end

endmodule

// ===== src/k_winner_column_select.sv =====
// Top level: k-winners-take-all column select, front end, queue and selection engine.
//
// Column scores arrive one word per cycle on col_in, while col_in.ready is high, in
// column index order and are written to a 1024-entry score memory; the word with
// last_column set closes the set and starts selection. Words beyond 1024 columns are
// dropped, though their last mark still closes the set. Selection emits
// min(winner_count, 64) words on win_out: each round scans the loaded columns from
// index 0 up, picks the first column with the strictly largest positive score (index
// 0 if none is left), then zeroes that score, so index 0 may repeat. last_winner
// flags the final word of a set; winner_count of zero closes the set with no output.
// A column word passes through the front end into the two-entry command queue.
// Selection is paced by the single port of the score memory (one column read per
// cycle, one write per round). The front end keeps accepting words while selection
// runs until the queue fills. The user must write winner_count through cfg_we /
// cfg_wdata only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
module k_winner_column_select (
  input  logic                         clk,
  input  logic                         rst,
  kwcs_col_if.sink                     col_in,
  kwcs_win_if.source                   win_out,
  input  logic                         cfg_we,
  input  logic [kwcs_pkg::WC_BITS-1:0] cfg_wdata
);

  logic [kwcs_pkg::WC_BITS-1:0] winner_count;

  // front-to-queue and queue-to-engine command path
  logic                   push;
  logic                   pop;
  kwcs_pkg::cmd_t         wr_cmd;
  kwcs_pkg::cmd_t         rd_cmd;
  kwcs_pkg::fifo_status_t fifo_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      winner_count <= kwcs_pkg::WC_BITS'(1);
    end else if (cfg_we) begin
      winner_count <= cfg_wdata;
    end
  end

  kwcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .col_in      (col_in),
    .fifo_status (fifo_status),
    .push        (push),
    .cmd         (wr_cmd)
  );

  kwcs_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .status (fifo_status)
  );

  kwcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (rd_cmd),
    .fifo_status  (fifo_status),
    .winner_count (winner_count),
    .pop          (pop),
    .win_out      (win_out)
  );

  // front end never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_status.full)
    else $error("command pushed into full queue");

  // engine never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_status.empty)
    else $error("command popped from empty queue");

  // a queue that is full and not drained stays full and stalls the input side
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    fifo_status.full && !pop |=> fifo_status.full && !col_in.ready)
    else $error("queue fill lost a command");

endmodule
